// ===== rtl/epr_pkg.sv =====
package epr_pkg;

  // Store geometry and delay width.
  localparam int MAX_STEPS  = 64;
  localparam int DELAY_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_STEPS);
  localparam int CNT_W      = $clog2(MAX_STEPS + 1);
  localparam int CFG_W      = 16;

  localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_TICK  = 2'd1,
    OP_MODE  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    MODE_INACTIVE  = 2'd0,
    MODE_ACTIVE    = 2'd1,
    MODE_RECORDING = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_WSTART,
    S_WRD
  } state_t;

  // One stored step: the button event and the ticks that follow it.
  typedef struct packed {
    logic [DELAY_BITS-1:0] delay;
    logic                  press_kind;
    logic [3:0]            row;
    logic [3:0]            column;
    logic [3:0]            target;
  } step_t;

  // Access request from the sequencer to the step store.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    step_t            wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

endpackage

// ===== rtl/event_pattern_recorder_looper.sv =====
// Event pattern recorder and looper.
// Record events and mode changes complete in the idle state. A recording tick
// reads the current step, then writes back its bumped delay in S_RMW. A playback
// walk runs S_WSTART then S_WRD (via S_RMW on expiry); output stalls hold it.
// Results leave at most one per cycle through a registered output stage.
// Reset (rst_n, synchronous, active low) clears mode, counters and handshakes;
// the step store is not cleared and needs no clearing pass.
module event_pattern_recorder_looper
  import epr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // Input channel.
  input  logic             in_tvalid,
  output logic             in_tready,
  // tdata fields from bit 0: target[3:0], column[7:4], row[11:8], press_kind[12],
  // new_mode[14:13], zero [15].
  input  logic [15:0]      in_tdata,
  // tuser fields from bit 0: operation[1:0].
  input  logic [1:0]       in_tuser,
  // Result channel.
  output logic             out_tvalid,
  input  logic             out_tready,
  // tdata fields from bit 0: out_target[3:0], out_column[7:4], out_row[11:8],
  // out_press_kind[12], zero [15:13].
  output logic [15:0]      out_tdata,
  // tlast carries last_of_tick.
  output logic             out_tlast,
  // Configuration channel: auto_stop_ticks.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  // Unpacked input fields.
  logic [3:0] f_target;
  logic [3:0] f_column;
  logic [3:0] f_row;
  logic       f_press;
  logic [1:0] f_mode;

  assign f_target = in_tdata[3:0];
  assign f_column = in_tdata[7:4];
  assign f_row    = in_tdata[11:8];
  assign f_press  = in_tdata[12];
  assign f_mode   = in_tdata[14:13];

  // Control state.
  state_t                state_r, state_nxt;
  mode_t                 mode_r, mode_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      cursor_r, cursor_nxt;
  logic [DELAY_BITS-1:0] wait_r, wait_nxt;
  logic [CFG_W-1:0]      auto_stop_r;

  // Walk state: index of the entry whose data is being read, emitted count,
  // and the step held back until the next delay decides its last flag.
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic                  have_pend_r, have_pend_nxt;
  step_t                 pend_r, pend_nxt;

  // Output stage.
  logic                  out_valid_r, out_valid_nxt;
  step_t                 out_step_r, out_step_nxt;
  logic                  out_last_r, out_last_nxt;

  mem_req_t              req;
  step_t                 rd_data;

  logic                  in_xfer;
  logic                  out_free;
  logic [IDX_W-1:0]      idx_next;
  logic [CNT_W-1:0]      idx_inc;
  logic [IDX_W-1:0]      rec_cursor;
  logic [IDX_W-1:0]      walk_start;
  logic [IDX_W-1:0]      last_idx;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // Walk wraps past the last stored step back to step 0.
  assign idx_inc  = CNT_W'(idx_r) + CNT_W'(1);
  assign idx_next = (idx_inc < count_r) ? idx_r + IDX_W'(1) : '0;

  assign last_idx   = IDX_W'(count_r - CNT_W'(1));
  assign rec_cursor = (CNT_W'(cursor_r) < count_r) ? cursor_r : last_idx;
  assign walk_start = (CNT_W'(cursor_r) < count_r) ? cursor_r : '0;

  epr_step_mem u_mem (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_INACTIVE;
      count_r     <= '0;
      cursor_r    <= '0;
      wait_r      <= '0;
      auto_stop_r <= '0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      wait_r      <= wait_nxt;
      have_pend_r <= have_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        auto_stop_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    pend_r     <= pend_nxt;
    out_step_r <= out_step_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    wait_nxt      = wait_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    have_pend_nxt = have_pend_r;
    pend_nxt      = pend_r;
    out_step_nxt  = out_step_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;

    req         = '0;
    req.wr_addr = rec_cursor;
    req.rd_addr = rec_cursor;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (op_t'(in_tuser))
            OP_EVENT: begin
              // Append while recording; a full store drops the event.
              if (mode_r == MODE_RECORDING && count_r < CNT_W'(MAX_STEPS)) begin
                req.wr_en              = 1'b1;
                req.wr_addr            = IDX_W'(count_r);
                req.wr_data.target     = f_target;
                req.wr_data.column     = f_column;
                req.wr_data.row        = f_row;
                req.wr_data.press_kind = f_press;
                req.wr_data.delay      = '0;
                cursor_nxt             = IDX_W'(count_r);
                count_nxt              = count_r + CNT_W'(1);
              end
            end
            OP_MODE: begin
              if (f_mode == MODE_INACTIVE || f_mode == MODE_ACTIVE ||
                  f_mode == MODE_RECORDING) begin
                // Leaving recording parks the cursor on the last step.
                if (mode_r == MODE_RECORDING) begin
                  cursor_nxt = (count_r != '0) ? last_idx : '0;
                  wait_nxt   = '0;
                end
                mode_nxt = mode_t'(f_mode);
                if (f_mode == MODE_RECORDING) begin
                  wait_nxt = DELAY_BITS'(auto_stop_r);
                end
              end
            end
            OP_TICK: begin
              if (mode_r == MODE_RECORDING) begin
                // Read the current step; its delay is bumped next cycle.
                if (count_r != '0) begin
                  req.rd_en = 1'b1;
                  state_nxt = S_RMW;
                end
              end else if (mode_r == MODE_ACTIVE) begin
                if (wait_r != '0) begin
                  wait_nxt = wait_r - DELAY_BITS'(1);
                end else if (count_r != '0) begin
                  state_nxt = S_WSTART;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RMW: begin
        // Saturating delay increment, written back to the same entry.
        req.wr_en   = 1'b1;
        req.wr_data = rd_data;
        if (rd_data.delay != DELAY_MAX) begin
          req.wr_data.delay = rd_data.delay + DELAY_BITS'(1);
        end
        state_nxt = S_IDLE;
        if (wait_r != '0) begin
          wait_nxt = wait_r - DELAY_BITS'(1);
          // Countdown expiry ends recording and plays from the last step.
          if (wait_r == DELAY_BITS'(1)) begin
            mode_nxt   = MODE_ACTIVE;
            cursor_nxt = last_idx;
            state_nxt  = S_WSTART;
          end
        end
      end

      S_WSTART: begin
        // The write from a recording tick has landed, so this read sees it.
        req.rd_en     = 1'b1;
        req.rd_addr   = walk_start;
        idx_nxt       = walk_start;
        n_nxt         = '0;
        have_pend_nxt = 1'b0;
        state_nxt     = S_WRD;
      end

      S_WRD: begin
        if (!have_pend_r) begin
          // First step of the walk: hold it and fetch its successor.
          pend_nxt      = rd_data;
          have_pend_nxt = 1'b1;
          n_nxt         = CNT_W'(1);
          idx_nxt       = idx_next;
          req.rd_en     = 1'b1;
          req.rd_addr   = idx_next;
        end else if (out_free) begin
          // The successor's delay decides whether the held step ends the tick.
          out_valid_nxt = 1'b1;
          out_step_nxt  = pend_r;
          if (rd_data.delay == '0 && n_r < count_r) begin
            out_last_nxt = 1'b0;
            pend_nxt     = rd_data;
            n_nxt        = n_r + CNT_W'(1);
            idx_nxt      = idx_next;
            req.rd_en    = 1'b1;
            req.rd_addr  = idx_next;
          end else begin
            out_last_nxt = 1'b1;
            cursor_nxt   = idx_r;
            wait_nxt     = rd_data.delay;
            state_nxt    = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_step_r.press_kind, out_step_r.row,
                       out_step_r.column, out_step_r.target};

endmodule

// ===== rtl/epr_step_mem.sv =====
module epr_step_mem
  import epr_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output step_t    rd_data
);

  step_t mem [MAX_STEPS];
  step_t rd_data_r;

  // Read data holds while no read is issued, so a stalled consumer keeps it.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
